[hw/rtl/fptw_pkg.sv]
package fptw_pkg;

  // geometry that never varies
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned FRAME_NUM_W       = 40;
  localparam int unsigned STEP_W            = 4;

  // entry bit positions
  localparam int unsigned BIT_PRESENT  = 0;
  localparam int unsigned BIT_WRITABLE = 1;
  localparam int unsigned BIT_USER     = 2;

  localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;

  typedef logic [STEP_W-1:0] step_t;

  // micro-operations
  typedef enum logic [2:0] {
    OP_EMIT,
    OP_READ,
    OP_MAP_EVAL,
    OP_LOOK_EVAL,
    OP_WRITE_LEAF,
    OP_CAPTURE
  } uop_t;

  // entry points of the two programs and the shared result step
  localparam step_t STEP_MAP  = 4'd0;
  localparam step_t STEP_LOOK = 4'd7;
  localparam step_t STEP_EMIT = 4'd15;

  typedef struct packed {
    uop_t        op;
    logic [1:0]  lvl;
    step_t       next;
    step_t       alt;
  } ctrl_word_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic        active;
    uop_t        op;
    logic [1:0]  lvl;
    logic        emit;
  } seq_ctrl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic        fail;
    logic        clearing;
  } dp_stat_t;

  // control store: one word per step, alt is taken when the step fails
  function automatic ctrl_word_t ctrl_rom(input step_t s);
    ctrl_word_t w;
    w = '{op: OP_EMIT, lvl: 2'd0, next: STEP_EMIT, alt: STEP_EMIT};
    case (s)
      4'd0:  w = '{op: OP_READ,       lvl: 2'd0, next: 4'd1,      alt: STEP_EMIT};
      4'd1:  w = '{op: OP_MAP_EVAL,   lvl: 2'd0, next: 4'd2,      alt: STEP_EMIT};
      4'd2:  w = '{op: OP_READ,       lvl: 2'd1, next: 4'd3,      alt: STEP_EMIT};
      4'd3:  w = '{op: OP_MAP_EVAL,   lvl: 2'd1, next: 4'd4,      alt: STEP_EMIT};
      4'd4:  w = '{op: OP_READ,       lvl: 2'd2, next: 4'd5,      alt: STEP_EMIT};
      4'd5:  w = '{op: OP_MAP_EVAL,   lvl: 2'd2, next: 4'd6,      alt: STEP_EMIT};
      4'd6:  w = '{op: OP_WRITE_LEAF, lvl: 2'd3, next: STEP_EMIT, alt: STEP_EMIT};
      4'd7:  w = '{op: OP_READ,       lvl: 2'd0, next: 4'd8,      alt: STEP_EMIT};
      4'd8:  w = '{op: OP_LOOK_EVAL,  lvl: 2'd0, next: 4'd9,      alt: STEP_EMIT};
      4'd9:  w = '{op: OP_READ,       lvl: 2'd1, next: 4'd10,     alt: STEP_EMIT};
      4'd10: w = '{op: OP_LOOK_EVAL,  lvl: 2'd1, next: 4'd11,     alt: STEP_EMIT};
      4'd11: w = '{op: OP_READ,       lvl: 2'd2, next: 4'd12,     alt: STEP_EMIT};
      4'd12: w = '{op: OP_LOOK_EVAL,  lvl: 2'd2, next: 4'd13,     alt: STEP_EMIT};
      4'd13: w = '{op: OP_READ,       lvl: 2'd3, next: 4'd14,     alt: STEP_EMIT};
      4'd14: w = '{op: OP_CAPTURE,    lvl: 2'd3, next: STEP_EMIT, alt: STEP_EMIT};
      default: w = '{op: OP_EMIT,     lvl: 2'd0, next: STEP_EMIT, alt: STEP_EMIT};
    endcase
    return w;
  endfunction

  // table index for a level, PML4 first
  function automatic logic [IDX_W-1:0] vidx(input logic [47:0] va, input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    r = va[20:12];
    case (lvl)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/four_level_page_table_map_walk.sv]
// channel   direction  handshake               payload
// cfg       in         cfg_wr_en               cfg_wr_data (table_base_frame)
// in        in         in_valid / in_stall     cmd, vaddr, paddr, page_flags
// out       out        out_valid / out_stall   ok, leaf_entry
//
// one item at a time: a map reads and then writes each upper level and writes the leaf, a
// lookup reads each level, and a level that fails ends the walk early; the table memory is single-port
// after reset a clearing pass writes all TABLE_FRAMES*512 entries of the table memory
// with in_stall high; configuration writes are taken throughout
// a finished result sits in the output register while the next item is taken; the
// sequencer holds on its result step while that register is full and stalled
module four_level_page_table_map_walk #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [39:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [47:0] vaddr,
  input  logic [51:0] paddr,
  input  logic [63:0] page_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [63:0] leaf_entry
);

  logic                busy;
  logic                accept;
  logic                out_free;
  logic                res_ok;
  logic [63:0]         res_leaf;
  fptw_pkg::seq_ctrl_t ctrl;
  fptw_pkg::dp_stat_t  stat;

  // input and output handshakes
  always_comb begin
    in_stall = busy || stat.clearing;
    accept   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
  end

  fptw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .start_cmd (cmd),
    .out_free  (out_free),
    .stat      (stat),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  fptw_dp #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .load        (accept),
    .vaddr       (vaddr),
    .paddr       (paddr),
    .page_flags  (page_flags),
    .ctrl        (ctrl),
    .stat        (stat),
    .res_ok      (res_ok),
    .res_leaf    (res_leaf)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      ok         <= res_ok;
      leaf_entry <= res_leaf;
    end
  end

endmodule

[hw/rtl/fptw_ram.sv]
module fptw_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/fptw_seq.sv]
module fptw_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                start_cmd,
  input  logic                out_free,
  input  fptw_pkg::dp_stat_t  stat,
  output logic                busy,
  output fptw_pkg::seq_ctrl_t ctrl
);

  fptw_pkg::step_t      step;
  fptw_pkg::ctrl_word_t word;

  // control word of the current step
  always_comb begin
    word        = fptw_pkg::ctrl_rom(step);
    ctrl.active = busy;
    ctrl.op     = word.op;
    ctrl.lvl    = word.lvl;
    ctrl.emit   = busy && (word.op == fptw_pkg::OP_EMIT) && out_free;
  end

  // step counter with conditional jump on failure
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= fptw_pkg::STEP_MAP;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= start_cmd ? fptw_pkg::STEP_LOOK : fptw_pkg::STEP_MAP;
      end
    end else if (word.op == fptw_pkg::OP_EMIT) begin
      if (out_free) begin
        busy <= 1'b0;
      end
    end else begin
      step <= stat.fail ? word.alt : word.next;
    end
  end

endmodule

[hw/rtl/fptw_dp.sv]
module fptw_dp #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [39:0]         cfg_wr_data,
  input  logic                load,
  input  logic [47:0]         vaddr,
  input  logic [51:0]         paddr,
  input  logic [63:0]         page_flags,
  input  fptw_pkg::seq_ctrl_t ctrl,
  output fptw_pkg::dp_stat_t  stat,
  output logic                res_ok,
  output logic [63:0]         res_leaf
);

  localparam int unsigned FW    = $clog2(TABLE_FRAMES);
  localparam int unsigned CW    = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned AW    = FW + fptw_pkg::IDX_W;
  localparam int unsigned DEPTH = TABLE_FRAMES * fptw_pkg::ENTRIES_PER_TABLE;

  logic [39:0]    base;
  logic [47:0]    va;
  logic [39:0]    pa_frame;
  logic [63:0]    flags;
  logic [FW-1:0]  t;
  logic [CW-1:0]  nff;
  logic [CW-1:0]  nff_next;
  logic           clearing;
  logic [AW-1:0]  clr_addr;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [64:0]    ram_wdata;
  logic [64:0]    ram_rdata;

  logic [63:0]    entry;
  logic [63:0]    entry_upd;
  logic [39:0]    off;
  logic           in_range;
  logic           present;
  logic           can_alloc;
  logic           alloc;
  logic           is_map_eval;
  logic           is_look_eval;
  logic           is_leaf_wr;
  logic [39:0]    new_pfn;
  logic [63:0]    new_entry;
  logic [63:0]    leaf_new;
  logic           wr_tag;

  // table store, top bit marks an entry written while its frame was allocated
  fptw_ram #(
    .WIDTH (65),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // entry as seen: zero when written before its frame was handed out
  always_comb begin
    entry = (ram_rdata[64] == (CW'(t) < nff)) ? ram_rdata[63:0] : 64'd0;
    present   = entry[fptw_pkg::BIT_PRESENT];
    entry_upd = entry | (flags & (64'd1 << fptw_pkg::BIT_USER));
    off       = entry[51:12] - base;
    in_range  = off < 40'(TABLE_FRAMES);
    can_alloc = nff < CW'(TABLE_FRAMES);
  end

  // level evaluation and allocation
  always_comb begin
    is_map_eval  = ctrl.active && (ctrl.op == fptw_pkg::OP_MAP_EVAL);
    is_look_eval = ctrl.active && (ctrl.op == fptw_pkg::OP_LOOK_EVAL);
    is_leaf_wr   = ctrl.active && (ctrl.op == fptw_pkg::OP_WRITE_LEAF);
    alloc        = is_map_eval && !present && can_alloc;
    nff_next     = alloc ? nff + CW'(1) : nff;
    new_pfn      = base + 40'(nff);
    new_entry    = {12'd0, new_pfn, 12'd0}
                 | (64'd1 << fptw_pkg::BIT_PRESENT)
                 | (64'd1 << fptw_pkg::BIT_WRITABLE)
                 | (flags & (64'd1 << fptw_pkg::BIT_USER));
    leaf_new     = {12'd0, pa_frame, 12'd0} | flags | (64'd1 << fptw_pkg::BIT_PRESENT);
    wr_tag       = CW'(t) < nff_next;
    stat.clearing = clearing;
    stat.fail    = (is_map_eval && (present ? !in_range : !can_alloc))
                 || (is_look_eval && (!present || !in_range));
  end

  // memory port
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr;
      ram_wdata = 65'd0;
    end else begin
      ram_we    = (is_map_eval && (present || can_alloc)) || is_leaf_wr;
      ram_addr  = {t, fptw_pkg::vidx(va, ctrl.lvl)};
      if (is_leaf_wr) begin
        ram_wdata = {wr_tag, leaf_new};
      end else if (present) begin
        ram_wdata = {wr_tag, entry_upd};
      end else begin
        ram_wdata = {wr_tag, new_entry};
      end
    end
  end

  // control state: clearing pass, allocator, base register
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      nff      <= CW'(1);
      base     <= 40'd256;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      nff <= nff_next;
      if (cfg_wr_en) begin
        base <= cfg_wr_data;
      end
    end
  end

  // item fields, current frame and result
  always_ff @(posedge clk) begin
    if (load) begin
      va       <= vaddr;
      pa_frame <= paddr[51:12];
      flags    <= page_flags;
      t        <= '0;
      res_ok   <= 1'b1;
      res_leaf <= 64'd0;
    end else if (is_map_eval) begin
      if (present) begin
        if (in_range) begin
          t <= off[FW-1:0];
        end else begin
          res_ok <= 1'b0;
        end
      end else if (can_alloc) begin
        t <= nff[FW-1:0];
      end else begin
        res_ok <= 1'b0;
      end
    end else if (is_look_eval) begin
      if (present && in_range) begin
        t <= off[FW-1:0];
      end
    end else if (ctrl.active && (ctrl.op == fptw_pkg::OP_CAPTURE)) begin
      res_leaf <= entry;
    end
  end

endmodule

[dv/tb_four_level_page_table_map_walk.sv]
`timescale 1ns / 1ps

module tb_four_level_page_table_map_walk;

  localparam int unsigned TABLE_FRAMES = 16;
  localparam int unsigned TABLE_SLOTS  = TABLE_FRAMES * fptw_pkg::ENTRIES_PER_TABLE;

  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [39:0] RESET_BASE = 40'd256;
  localparam logic [39:0] MAX_BASE   = 40'hFF_FFFF_FFFF;

  localparam logic [63:0] PRESENT_MASK  = 64'd1 << fptw_pkg::BIT_PRESENT;
  localparam logic [63:0] WRITABLE_MASK = 64'd1 << fptw_pkg::BIT_WRITABLE;
  localparam logic [63:0] USER_MASK     = 64'd1 << fptw_pkg::BIT_USER;

  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct {
    logic        cmd;
    logic [47:0] va;
    logic [51:0] pa;
    logic [63:0] flags;
  } walk_item_t;

  typedef struct {
    logic        ok;
    logic [63:0] leaf;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [39:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [47:0] vaddr;
  logic [51:0] paddr;
  logic [63:0] page_flags;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [63:0] leaf_entry;

  // shadow copy of the page tables and allocator
  logic [63:0] shadow_table [TABLE_SLOTS];
  int unsigned shadow_next_frame;
  logic [39:0] shadow_base;

  walk_result_t pending_results[$];
  logic [47:0]  mapped_pages[$];

  int unsigned err_count;
  int unsigned n_maps;
  int unsigned n_lookups;
  int unsigned n_map_fail;
  int unsigned n_lookup_hit;

  logic        tx_idle;
  logic        rx_idle;
  int unsigned rx_hold_cycles;

  four_level_page_table_map_walk #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .vaddr       (vaddr),
    .paddr       (paddr),
    .page_flags  (page_flags),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .leaf_entry  (leaf_entry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("tb_four_level_page_table_map_walk: errors");
    $finish;
  end

  // 9-bit table index at a given shift
  function automatic logic [8:0] level_index(input logic [47:0] va, input int unsigned shift);
    logic [47:0] s;
    s = va >> shift;
    return s[8:0];
  endfunction

  // internal frame that an entry points at, if any
  function automatic logic frame_of_entry(input logic [63:0] entry,
                                          output int unsigned frame);
    logic [39:0] off;
    off = entry[51:12] - shadow_base;
    frame = off[31:0];
    return (off < TABLE_FRAMES);
  endfunction

  // one level of a map: reuse a present entry or hang a new frame under it
  function automatic logic step_down(input int unsigned tbl, input logic [8:0] idx,
                                     input logic [63:0] flags, output int unsigned nxt);
    int unsigned s;
    int unsigned f;
    logic [63:0] e;
    logic [39:0] pfn;
    s = tbl * fptw_pkg::ENTRIES_PER_TABLE + idx;
    e = shadow_table[s];
    nxt = 0;
    if (e[fptw_pkg::BIT_PRESENT]) begin
      e = e | (flags & USER_MASK);
      shadow_table[s] = e;
      return frame_of_entry(e, nxt);
    end
    if (shadow_next_frame >= TABLE_FRAMES) return 1'b0;
    f = shadow_next_frame;
    shadow_next_frame++;
    for (int i = 0; i < fptw_pkg::ENTRIES_PER_TABLE; i++)
      shadow_table[f * fptw_pkg::ENTRIES_PER_TABLE + i] = '0;
    pfn = shadow_base + f;
    shadow_table[s] = {12'h000, pfn, 12'h000} | PRESENT_MASK | WRITABLE_MASK
                      | (flags & USER_MASK);
    nxt = f;
    return 1'b1;
  endfunction

  // expected result of one item, updating the shadow tables
  function automatic walk_result_t predict_walk(input walk_item_t it);
    walk_result_t r;
    int unsigned t;
    logic [63:0] e;
    t = 0;
    r.ok = 1'b1;
    r.leaf = '0;
    if (it.cmd == CMD_MAP) begin
      for (int lvl = 0; lvl < 3; lvl++) begin
        if (!step_down(t, level_index(it.va, 39 - 9 * lvl), it.flags, t)) begin
          r.ok = 1'b0;
          return r;
        end
      end
      shadow_table[t * fptw_pkg::ENTRIES_PER_TABLE + level_index(it.va, 12)] =
        ({12'h000, it.pa} & fptw_pkg::ADDR_MASK) | it.flags | PRESENT_MASK;
      return r;
    end
    for (int lvl = 0; lvl < 3; lvl++) begin
      e = shadow_table[t * fptw_pkg::ENTRIES_PER_TABLE + level_index(it.va, 39 - 9 * lvl)];
      if (!e[fptw_pkg::BIT_PRESENT] || !frame_of_entry(e, t)) return r;
    end
    r.leaf = shadow_table[t * fptw_pkg::ENTRIES_PER_TABLE + level_index(it.va, 12)];
    return r;
  endfunction

  // offer one item, wait for it to be taken, then record what it should give
  task automatic send_item(input logic c, input logic [47:0] va, input logic [51:0] pa,
                           input logic [63:0] flags);
    int unsigned gap;
    walk_item_t it;
    walk_result_t want;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    cmd        <= c;
    vaddr      <= va;
    paddr      <= pa;
    page_flags <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    it.cmd   = c;
    it.va    = va;
    it.pa    = pa;
    it.flags = flags;
    want = predict_walk(it);
    pending_results.push_back(want);
    if (c == CMD_MAP) begin
      n_maps++;
      if (!want.ok) n_map_fail++;
      // remember pages that resolve under the default base for later reuse
      if (want.ok && shadow_base == RESET_BASE && mapped_pages.size() < 256)
        mapped_pages.push_back(va);
    end else begin
      n_lookups++;
      if (want.leaf != '0) n_lookup_hit++;
    end
  endtask

  // drop valid, let every result come back and the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [39:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_base = value;
  endtask

  // mostly addresses near pages already mapped, some wholly random
  function automatic walk_item_t random_item();
    walk_item_t it;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] v;
    logic [47:0] seen;
    int unsigned pick;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    v = {$urandom, $urandom};
    it.cmd   = 1'($urandom_range(0, 1));
    it.pa    = a[51:0];
    it.flags = b;
    it.va    = v[47:0];
    pick = $urandom_range(0, 99);
    if (mapped_pages.size() != 0 && pick < 85) begin
      seen = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      if (pick < 35)      it.va[47:12] = seen[47:12];
      else if (pick < 65) it.va[47:21] = seen[47:21];
      else if (pick < 77) it.va[47:30] = seen[47:30];
      else                it.va[47:39] = seen[47:39];
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned count);
    walk_item_t it;
    repeat (count) begin
      it = random_item();
      send_item(it.cmd, it.va, it.pa, it.flags);
    end
  endtask

  // first walks under the reset base: creation, reuse, user bit, absent levels
  task automatic test_fresh_walks();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(CMD_LOOKUP, 48'h0, 52'h0, 64'h0);
    send_item(CMD_MAP, 48'h0, 52'h0, 64'h0);
    send_item(CMD_LOOKUP, 48'h0, 52'h0, 64'h0);
    send_item(CMD_MAP, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0);
    send_item(CMD_MAP, 48'h5 << 12, 52'h1_2345_6789_ABCD, USER_MASK);
    send_item(CMD_LOOKUP, 48'h5 << 12, 52'h0, 64'h0);
    send_item(CMD_LOOKUP, 48'h1 << 21, 52'h0, 64'h0);
    send_item(CMD_LOOKUP, 48'h1 << 12, 52'h0, 64'h0);
  endtask

  // moving the base makes old pointers foreign, wraps new ones, or aliases them
  task automatic test_base_moves();
    wait_idle();
    write_table_base(MAX_BASE);
    send_item(CMD_LOOKUP, 48'h0, 52'h0, 64'h0);
    send_item(CMD_MAP, 48'h0, 52'hA_BCDE_F012_3456, USER_MASK);
    send_item(CMD_MAP, 48'h2 << 39, 52'h5_5555_5555_5555, 64'h8000_0000_0000_0006);
    send_item(CMD_LOOKUP, 48'h2 << 39, 52'h0, 64'h0);
    wait_idle();
    write_table_base(40'd0);
    send_item(CMD_LOOKUP, 48'h2 << 39, 52'h0, 64'h0);
    send_item(CMD_MAP, 48'h2 << 39, 52'hA_AAAA_AAAA_AAAA, 64'h0);
    send_item(CMD_LOOKUP, 48'h2 << 39, 52'h0, 64'h0);
    wait_idle();
    write_table_base(RESET_BASE);
    send_item(CMD_LOOKUP, 48'h0, 52'h0, 64'h0);
  endtask

  // use up the last frames, with a map that fails part way down
  task automatic test_frame_exhaustion();
    send_item(CMD_MAP, 48'h3 << 39, 52'h0_0000_0000_1000, USER_MASK);
    send_item(CMD_MAP, 48'h4 << 39, 52'h0_0000_0000_2000, USER_MASK);
    send_item(CMD_LOOKUP, 48'h4 << 39, 52'h0, 64'h0);
    send_item(CMD_MAP, 48'h4 << 39, 52'h0_0000_0000_3000, 64'h0);
    send_item(CMD_MAP, 48'h7 << 12, 52'h0_0000_0000_4000, 64'h0);
  endtask

  task automatic test_random_walks();
    logic [63:0] r;
    run_random(380);
    wait_idle();
    r = {$urandom, $urandom};
    write_table_base(r[39:0]);
    run_random(100);
    wait_idle();
    write_table_base(RESET_BASE);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(100);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(150);
  endtask

  // receiver holds off while items keep coming, so the input backs up
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_hold_cycles = 300;
    run_random(12);
    tx_idle = 1'b1;
  endtask

  // result checker and receiver stall
  initial begin : result_checker
    int unsigned stall_left;
    walk_result_t want;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0d ns: result with nothing expected, ok %0d leaf_entry %h",
                   $time, ok, leaf_entry);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (ok !== want.ok) begin
            $display("%0d ns: ok expected %0d got %0d", $time, want.ok, ok);
            err_count++;
          end
          if (leaf_entry !== want.leaf) begin
            $display("%0d ns: leaf_entry expected %h got %h", $time, want.leaf, leaf_entry);
            err_count++;
          end
        end
        stall_left = rx_idle ? $urandom_range(0, 19) : 0;
      end
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_stall <= 1'b1;
        rx_hold_cycles--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    cmd            = CMD_MAP;
    vaddr          = '0;
    paddr          = '0;
    page_flags     = '0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    rx_hold_cycles = 0;
    err_count      = 0;
    n_maps         = 0;
    n_lookups      = 0;
    n_map_fail     = 0;
    n_lookup_hit   = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) shadow_table[i] = '0;
    shadow_next_frame = 1;
    shadow_base       = RESET_BASE;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_fresh_walks();
    test_base_moves();
    test_frame_exhaustion();
    test_random_walks();
    test_output_backpressure();

    wait_idle();
    $display("covered %0d maps (%0d refused) and %0d lookups (%0d found a leaf)",
             n_maps, n_map_fail, n_lookups, n_lookup_hit);
    $display("table bases: reset, top of range, zero and a random one; %0d frames taken",
             shadow_next_frame);
    if (err_count == 0) begin
      $display("tb_four_level_page_table_map_walk: clean");
    end else begin
      $display("tb_four_level_page_table_map_walk: errors");
    end
    $finish;
  end

endmodule
